[design/itpt_pkg.sv]
// shared types, codes and constants of the integer to prefixed text converter
`timescale 1ns / 1ps

package itpt_pkg;

    // text limits and field widths
    localparam int MAX_TEXT   = 64;
    localparam int BUF_W      = 7;
    localparam int VALUE_W    = 32;
    localparam int NBITS_W    = 8;
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 6;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // opcodes
    localparam logic [OP_W-1:0] OP_UBIN = 2'd0;
    localparam logic [OP_W-1:0] OP_SBIN = 2'd1;
    localparam logic [OP_W-1:0] OP_HEX  = 2'd2;
    localparam logic [OP_W-1:0] OP_BAD  = 2'd3;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPA   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWB  = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LOWX  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    // outcome of the request check
    typedef struct packed {
        logic             err;
        logic             hex;
        logic             sign_fill;
        logic [LEN_W-1:0] len;
    } check_t;

    // one hex digit to uppercase ascii
    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'd0, d};
        end
        else
        begin
            c = CH_UPA + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

[design/itpt_check.sv]
// request check: width, buffer room, magnitude and hex width tests
`timescale 1ns / 1ps

module itpt_check
(
    input  logic [itpt_pkg::OP_W-1:0]    op,
    input  logic [itpt_pkg::VALUE_W-1:0] value,
    input  logic [itpt_pkg::NBITS_W-1:0] digit_bits,
    input  logic [itpt_pkg::BUF_W-1:0]   buffer_size,
    output itpt_pkg::check_t             chk
);
    import itpt_pkg::*;

    logic [BUF_W-1:0]   size_eff;
    logic [8:0]         need;
    logic [8:0]         room;
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic               narrow;
    logic               over_u;
    logic               over_s;
    logic               hex_ok;
    logic               err;
    logic [LEN_W-1:0]   ndig;

    // effective buffer size and room needed
    assign size_eff = (buffer_size > BUF_W'(MAX_TEXT)) ? BUF_W'(MAX_TEXT) : buffer_size;
    assign need     = {1'b0, digit_bits} + 9'd3;
    assign room     = {2'b00, size_eff};

    // magnitude tests: any set bit at or above the digit width
    assign neg    = value[VALUE_W-1];
    assign mag    = neg ? (VALUE_W'(0) - value) : value;
    assign narrow = (digit_bits[7:5] == 3'd0);
    assign over_u = narrow && ((value >> digit_bits[4:0]) != '0);
    assign over_s = narrow && ((mag >> digit_bits[4:0]) != '0);

    // hex widths allowed
    always_comb
    begin
        hex_ok = digit_bits inside {8'd4, 8'd8, 8'd16, 8'd32};
    end

    // rejection per opcode
    always_comb
    begin
        err = 1'b0;
        case (op)
            OP_UBIN: err = (room <= need) || over_u;
            OP_SBIN: err = (room < need) || over_s;
            OP_HEX:  err = (room <= need) || !hex_ok || over_u;
            OP_BAD:  err = 1'b1;
            default: err = 1'b1;
        endcase
        if (digit_bits == '0)
        begin
            err = 1'b1;
        end
    end

    // digit count and text length
    assign ndig = (op == OP_HEX) ? {2'b00, digit_bits[5:2]} : digit_bits[5:0];

    assign chk.err       = err;
    assign chk.hex       = (op == OP_HEX);
    assign chk.sign_fill = (op == OP_SBIN) && neg;
    assign chk.len       = ndig + LEN_W'(2);

endmodule

[design/integer_to_prefixed_text_top.sv]
// top level of the integer to prefixed text converter
`timescale 1ns / 1ps

// Converts one 32-bit value per request into ASCII text, most significant
// character first: "0b" plus unsigned or signed binary, or "0x" plus hex.
// Slave channel: tuser = opcode, tdata = value then digit_bits.
// Master channel: one character per item, tlast on the final one,
// tuser = error flag; a rejected request gives a single item with error set.
// Config channel: cfg_data sets the buffer size (reset 64); the user must
// write it only when idle; the block itself does not enforce this.
// Sequence: the request is registered, then checked, then characters go
// out one per cycle while the receiver keeps up, from a single shared
// character unit driven by a position counter, at most 63 characters.
// The block takes a new request only when idle; the output register lets it
// take one while its last character is still waiting.
// A stalled receiver holds the output register and freezes character output.
// Reset empties the output register, returns to idle, sets buffer size 64.

module integer_to_prefixed_text_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // value [31:0], digit_bits [39:32]
    input  logic [itpt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode [1:0]
    input  logic [itpt_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // text_char [7:0], text_length [13:8], zero [15:14]
    output logic [itpt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast,
    // error [0]
    output logic                              m_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [itpt_pkg::BUF_W-1:0]        cfg_data
);
    import itpt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [BUF_W-1:0]   buf_reg;
    logic [OP_W-1:0]    op_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [NBITS_W-1:0] nb_reg;
    check_t             chk_reg, chk_next;
    check_t             chk;
    logic [LEN_W-1:0]   p_reg, p_next;
    logic               ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0]  ochar_reg, ochar_next;
    logic [LEN_W-1:0]   olen_reg, olen_next;
    logic               olast_reg, olast_next;
    logic               oerr_reg, oerr_next;
    logic               in_take;
    logic               out_free;
    logic [LEN_W-1:0]   pos;
    logic [3:0]         nibble;
    logic               bit_val;
    logic [CHAR_W-1:0]  cur_char;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ovalid_reg || m_axis_tready;

    // request check
    itpt_check u_check
    (
        .op          (op_reg),
        .value       (val_reg),
        .digit_bits  (nb_reg),
        .buffer_size (buf_reg),
        .chk         (chk)
    );

    // shared character unit: digit position counts down from the top
    assign pos    = chk_reg.len - LEN_W'(1) - p_reg;
    assign nibble = 4'(val_reg >> {pos[2:0], 2'b00});
    assign bit_val = pos[5] ? chk_reg.sign_fill : val_reg[pos[4:0]];

    always_comb
    begin
        if (p_reg == LEN_W'(0))
        begin
            cur_char = CH_ZERO;
        end
        else if (p_reg == LEN_W'(1))
        begin
            cur_char = chk_reg.hex ? CH_LOWX : CH_LOWB;
        end
        else if (chk_reg.hex)
        begin
            cur_char = hex_char(nibble);
        end
        else
        begin
            cur_char = CH_ZERO + {7'd0, bit_val};
        end
    end

    // sequencer and output register
    always_comb
    begin
        state_next  = state_reg;
        chk_next    = chk_reg;
        p_next      = p_reg;
        ovalid_next = ovalid_reg;
        ochar_next  = ochar_reg;
        olen_next   = olen_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                chk_next = chk;
                p_next   = '0;
                if (chk.err)
                begin
                    if (out_free)
                    begin
                        ovalid_next = 1'b1;
                        ochar_next  = CH_NUL;
                        olen_next   = '0;
                        olast_next  = 1'b1;
                        oerr_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = cur_char;
                    olen_next   = chk_reg.len;
                    olast_next  = (p_reg == chk_reg.len - LEN_W'(1));
                    oerr_next   = 1'b0;
                    if (p_reg == chk_reg.len - LEN_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        p_next = p_reg + LEN_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            buf_reg    <= BUF_W'(MAX_TEXT);
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready)
            begin
                buf_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= s_axis_tuser;
            val_reg <= s_axis_tdata[VALUE_W-1:0];
            nb_reg  <= s_axis_tdata[IN_DATA_W-1:VALUE_W];
        end
        chk_reg   <= chk_next;
        p_reg     <= p_next;
        ochar_reg <= ochar_next;
        olen_reg  <= olen_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    // output channel
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {2'b00, olen_reg, ochar_reg};
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = oerr_reg;

endmodule
